// ===== src/i2cbm_pkg.sv =====
package i2cbm_pkg;

  // Width of the delay counter; the configured delay is cut to this many bits.
  localparam int WAIT_WIDTH = 16;

  // Delay length after reset, in ticks.
  localparam logic [15:0] DELAY_RESET = 16'd50;

  // Request codes carried in req_type.
  localparam logic [2:0] REQ_NONE    = 3'd0;
  localparam logic [2:0] REQ_START   = 3'd1;
  localparam logic [2:0] REQ_RESTART = 3'd2;
  localparam logic [2:0] REQ_WRITE   = 3'd3;
  localparam logic [2:0] REQ_READ    = 3'd4;
  localparam logic [2:0] REQ_STOP    = 3'd5;

  // Sequencer step codes.
  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_RS_A = 5'd1;
  localparam logic [4:0] ST_ST_A = 5'd2;
  localparam logic [4:0] ST_ST_B = 5'd3;
  localparam logic [4:0] ST_TX_A = 5'd4;
  localparam logic [4:0] ST_TX_B = 5'd5;
  localparam logic [4:0] ST_TX_C = 5'd6;
  localparam logic [4:0] ST_TX_D = 5'd7;
  localparam logic [4:0] ST_TX_E = 5'd8;
  localparam logic [4:0] ST_TX_F = 5'd9;
  localparam logic [4:0] ST_FIN  = 5'd10;
  localparam logic [4:0] ST_RX_A = 5'd11;
  localparam logic [4:0] ST_RX_B = 5'd12;
  localparam logic [4:0] ST_RX_C = 5'd13;
  localparam logic [4:0] ST_RX_D = 5'd14;
  localparam logic [4:0] ST_RX_E = 5'd15;
  localparam logic [4:0] ST_RX_F = 5'd16;
  localparam logic [4:0] ST_RX_G = 5'd17;
  localparam logic [4:0] ST_SP_A = 5'd18;
  localparam logic [4:0] ST_SP_B = 5'd19;
  localparam logic [4:0] ST_SP_C = 5'd20;

  // One tick beat on the input channel.
  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] tx_byte;
    logic       last_read;
    logic       sda_in;
  } in_item_t;

  // One result beat on the output channel.
  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic       ack_ok;
    logic [7:0] rx_byte;
  } out_item_t;

endpackage

// ===== src/i2cbm_seq.sv =====
module i2cbm_seq import i2cbm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        step_en,
  input  in_item_t    item,
  input  logic [15:0] delay_ticks,
  output out_item_t   result
);

  // Sequencer state.
  logic [2:0]            cmd, cmd_next;
  logic [4:0]            step, step_next;
  logic [3:0]            bit_cnt, bit_cnt_next;
  logic [7:0]            shreg, shreg_next;
  logic [WAIT_WIDTH-1:0] wait_cnt, wait_cnt_next;
  logic                  scl, scl_next;
  logic                  sda, sda_next;
  logic                  nak, nak_next;
  logic                  ack, ack_next;
  logic [7:0]            rx_hold, rx_hold_next;

  // Working values for the action pass.
  logic                  run;
  logic                  done;
  logic [4:0]            st_e;
  logic [7:0]            sr_e;
  logic [3:0]            bc_e;
  logic [3:0]            bc_inc;
  logic [7:0]            sr_shl;
  logic [7:0]            sr_smp;
  logic [WAIT_WIDTH-1:0] wait_dec;
  logic [WAIT_WIDTH-1:0] delay_load;

  // Delay value, with zero treated as one.
  always_comb begin
    delay_load = WAIT_WIDTH'(delay_ticks);
    if (delay_load == '0) begin
      delay_load = {{(WAIT_WIDTH-1){1'b0}}, 1'b1};
    end
  end

  // Next state for one tick: count down the delay or accept a command, then run
  // the pin actions up to the next delay or to completion.
  always_comb begin
    cmd_next     = cmd;
    step_next    = step;
    bit_cnt_next = bit_cnt;
    shreg_next   = shreg;
    wait_cnt_next = wait_cnt;
    scl_next     = scl;
    sda_next     = sda;
    nak_next     = nak;
    ack_next     = ack;
    rx_hold_next = rx_hold;
    run          = 1'b0;
    done         = 1'b0;
    st_e         = step;
    sr_e         = shreg;
    bc_e         = bit_cnt;
    wait_dec     = (wait_cnt != '0) ? wait_cnt - 1'b1 : wait_cnt;

    if (cmd != REQ_NONE) begin
      wait_cnt_next = wait_dec;
      run = (wait_dec == '0);
    end else if (item.req_type >= REQ_START && item.req_type <= REQ_STOP) begin
      cmd_next = item.req_type;
      sr_e     = item.tx_byte;
      nak_next = item.last_read;
      run      = 1'b1;
      unique case (item.req_type)
        REQ_START:   st_e = ST_ST_A;
        REQ_RESTART: st_e = ST_RS_A;
        REQ_WRITE: begin
          st_e = ST_TX_A;
          bc_e = 4'd0;
        end
        REQ_READ:    st_e = ST_RX_A;
        default:     st_e = ST_SP_A;
      endcase
    end

    shreg_next   = sr_e;
    bit_cnt_next = bc_e;
    bc_inc       = bc_e + 4'd1;
    sr_shl       = {sr_e[6:0], 1'b0};
    sr_smp       = {sr_e[6:0], item.sda_in};

    if (run) begin
      unique case (st_e)
        ST_RS_A: begin
          sda_next = 1'b1;
          scl_next = 1'b1;
          wait_cnt_next = delay_load;
          step_next = ST_ST_A;
        end
        ST_ST_A: begin
          sda_next = 1'b0;
          wait_cnt_next = delay_load;
          step_next = ST_ST_B;
        end
        // Start ends with SCL low and falls straight into the first data bit.
        ST_ST_B: begin
          scl_next = 1'b0;
          bit_cnt_next = 4'd0;
          sda_next = sr_e[7];
          wait_cnt_next = delay_load;
          step_next = ST_TX_B;
        end
        ST_TX_A: begin
          sda_next = sr_e[7];
          wait_cnt_next = delay_load;
          step_next = ST_TX_B;
        end
        ST_TX_B: begin
          scl_next = 1'b1;
          wait_cnt_next = delay_load;
          step_next = ST_TX_C;
        end
        // Clock low, move to the next bit or release SDA for the ACK.
        ST_TX_C: begin
          scl_next = 1'b0;
          shreg_next = sr_shl;
          bit_cnt_next = bc_inc;
          wait_cnt_next = delay_load;
          if (bc_inc < 4'd8) begin
            sda_next = sr_shl[7];
            step_next = ST_TX_B;
          end else begin
            sda_next = 1'b1;
            step_next = ST_TX_E;
          end
        end
        ST_TX_D: begin
          sda_next = 1'b1;
          wait_cnt_next = delay_load;
          step_next = ST_TX_E;
        end
        ST_TX_E: begin
          scl_next = 1'b1;
          wait_cnt_next = delay_load;
          step_next = ST_TX_F;
        end
        ST_TX_F: begin
          ack_next = ~item.sda_in;
          scl_next = 1'b0;
          wait_cnt_next = delay_load;
          step_next = ST_FIN;
        end
        ST_RX_A: begin
          sda_next = 1'b1;
          bit_cnt_next = 4'd0;
          shreg_next = 8'd0;
          wait_cnt_next = delay_load;
          step_next = ST_RX_C;
        end
        ST_RX_B: begin
          wait_cnt_next = delay_load;
          step_next = ST_RX_C;
        end
        ST_RX_C: begin
          scl_next = 1'b1;
          wait_cnt_next = delay_load;
          step_next = ST_RX_D;
        end
        // Sample with SCL high, then either the next bit or the ACK/NAK answer.
        ST_RX_D: begin
          shreg_next = sr_smp;
          scl_next = 1'b0;
          bit_cnt_next = bc_inc;
          wait_cnt_next = delay_load;
          if (bc_inc < 4'd8) begin
            step_next = ST_RX_C;
          end else begin
            sda_next = nak_next;
            step_next = ST_RX_F;
          end
        end
        ST_RX_E: begin
          sda_next = nak_next;
          wait_cnt_next = delay_load;
          step_next = ST_RX_F;
        end
        ST_RX_F: begin
          scl_next = 1'b1;
          wait_cnt_next = delay_load;
          step_next = ST_RX_G;
        end
        ST_RX_G: begin
          scl_next = 1'b0;
          sda_next = 1'b0;
          rx_hold_next = sr_e;
          cmd_next = REQ_NONE;
          step_next = ST_IDLE;
          wait_cnt_next = '0;
          done = 1'b1;
        end
        ST_SP_A: begin
          sda_next = 1'b0;
          wait_cnt_next = delay_load;
          step_next = ST_SP_B;
        end
        ST_SP_B: begin
          scl_next = 1'b1;
          wait_cnt_next = delay_load;
          step_next = ST_SP_C;
        end
        ST_SP_C: begin
          sda_next = 1'b1;
          wait_cnt_next = delay_load;
          step_next = ST_FIN;
        end
        // Final step and any unused code end the command.
        default: begin
          cmd_next = REQ_NONE;
          step_next = ST_IDLE;
          wait_cnt_next = '0;
          done = 1'b1;
        end
      endcase
    end
  end

  // The result reflects the state after this tick.
  always_comb begin
    result.scl_out  = scl_next;
    result.sda_out  = sda_next;
    result.busy_res = (cmd_next != REQ_NONE);
    result.done_res = done;
    result.ack_ok   = ack_next;
    result.rx_byte  = rx_hold_next;
  end

  // State update on each accepted tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd      <= REQ_NONE;
      step     <= ST_IDLE;
      bit_cnt  <= 4'd0;
      shreg    <= 8'd0;
      wait_cnt <= '0;
      scl      <= 1'b1;
      sda      <= 1'b1;
      nak      <= 1'b0;
      ack      <= 1'b0;
      rx_hold  <= 8'd0;
    end else if (step_en) begin
      cmd      <= cmd_next;
      step     <= step_next;
      bit_cnt  <= bit_cnt_next;
      shreg    <= shreg_next;
      wait_cnt <= wait_cnt_next;
      scl      <= scl_next;
      sda      <= sda_next;
      nak      <= nak_next;
      ack      <= ack_next;
      rx_hold  <= rx_hold_next;
    end
  end

endmodule

// ===== src/i2c_bit_level_master.sv =====
// Bit-level I2C master sequencer.
// Input channel (in_valid, in_stall, in_item): one beat per timing tick. The
// beat carries the sampled SDA level and, while the block is idle, a command
// (start or restart with address, write byte, read byte with ACK/NAK, stop).
// Output channel (out_valid, out_stall, out_item): exactly one result beat per
// input beat, giving the SCL/SDA drive levels, busy, done, the last ACK and
// the last received byte.
// Configuration channel (cfg_valid, cfg_ready, cfg_data): writes delay_ticks,
// the length in ticks of every delay; cfg_ready is always high.
// An accepted tick's result is registered in the output or skid register. One
// tick is accepted every cycle while in_stall is low; the sequencer state
// update and the result logic sit between the state registers and the output
// register. When the receiver stalls, one more result is caught in a skid
// register and in_stall rises only while that register is full.
// Reset returns the sequencer to idle with both bus lines released high,
// empties the output side and sets delay_ticks to 50.
module i2c_bit_level_master import i2cbm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic [15:0] delay_ticks;
  logic        accept;
  logic        out_free;
  logic        skid_valid;
  out_item_t   skid_item;
  out_item_t   result;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid;
  assign accept    = in_valid & ~skid_valid;
  assign out_free  = ~out_valid | ~out_stall;

  // Delay register.
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_ticks <= DELAY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      delay_ticks <= cfg_data;
    end
  end

  i2cbm_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .step_en     (accept),
    .item        (in_item),
    .delay_ticks (delay_ticks),
    .result      (result)
  );

  // Output register with a one-beat skid stage behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        out_item   <= skid_item;
        skid_valid <= 1'b0;
      end else if (accept) begin
        out_valid <= 1'b1;
        out_item  <= result;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
      skid_item  <= result;
    end
  end

endmodule
